// ===== sv/integer_square_root_unit_defines.svh =====
// Assertion macros shared by the square root unit.
`ifndef INTEGER_SQUARE_ROOT_UNIT_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ISR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("isr assertion failed: label");

// Next-cycle implication, disabled during reset.
`define ISR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("isr assertion failed: label");

`endif

// ===== sv/isr_pkg.sv =====
`timescale 1ns / 1ps

package isr_pkg;

  localparam int unsigned OperandW      = 32;
  localparam int unsigned FracShift     = 12;
  localparam int unsigned RootW         = 22;
  localparam int unsigned RadW          = 2 * RootW;
  localparam int unsigned RemW          = RootW + 2;
  localparam int unsigned ItersPerStage = 2;
  localparam int unsigned NumStages     = RootW / ItersPerStage;

  localparam logic CmdPlain = 1'b0;
  localparam logic CmdFixed = 1'b1;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  rad;
  } isr_data_t;

  // One restoring step: bring down two radicand bits, produce one root bit.
  function automatic isr_data_t isr_iter(isr_data_t d);
    logic [RemW+1:0] acc;
    logic [RemW+1:0] trial;
    isr_data_t       r;
    acc   = {d.rem, d.rad[RadW-1 -: 2]};
    trial = {2'b00, d.root, 2'b01};
    r.rad = {d.rad[RadW-3:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = RemW'(acc - trial);
      r.root = {d.root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = acc[RemW-1:0];
      r.root = {d.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== sv/integer_square_root_unit.sv =====
// Channel   Direction  Handshake                   Beat payload
// input     in         in_valid_i / in_ready_o     command_i, operand_i
// output    out        out_valid_o / out_ready_i   root_o
//
// One beat accepted per cycle while in_ready_o is high; each result passes through
// 11 register stages of two root bits each (22 restoring steps).
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall at the output backs up stage by stage; empty stages keep filling,
// so in_ready_o falls only when every stage holds a beat.
`timescale 1ns / 1ps
`include "integer_square_root_unit_defines.svh"

module integer_square_root_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [isr_pkg::OperandW-1:0] operand_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [isr_pkg::RootW-1:0]    root_o
);

  logic               vld   [isr_pkg::NumStages+1];
  logic               rdy   [isr_pkg::NumStages+1];
  isr_pkg::isr_data_t data  [isr_pkg::NumStages+1];

  localparam int unsigned PadW = isr_pkg::RadW - isr_pkg::OperandW;

  always_comb begin
    data[0].rem  = '0;
    data[0].root = '0;
    unique case (command_i)
      isr_pkg::CmdFixed: data[0].rad = {operand_i, {isr_pkg::FracShift{1'b0}}};
      isr_pkg::CmdPlain: data[0].rad = {{PadW{1'b0}}, operand_i};
      default:           data[0].rad = {{PadW{1'b0}}, operand_i};
    endcase
  end

  assign vld[0]     = in_valid_i;
  assign in_ready_o = rdy[0];

  for (genvar s = 0; s < isr_pkg::NumStages; s++) begin : g_stage
    isr_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[s]),
      .ready_o (rdy[s]),
      .data_i  (data[s]),
      .valid_o (vld[s+1]),
      .ready_i (rdy[s+1]),
      .data_o  (data[s+1])
    );
  end

  assign rdy[isr_pkg::NumStages] = out_ready_i;
  assign out_valid_o             = vld[isr_pkg::NumStages];
  assign root_o                  = data[isr_pkg::NumStages].root;

  `ISR_ASSERT_IMPL(a_full_when_blocked, !in_ready_o, out_valid_o && !out_ready_i)
  `ISR_ASSERT_IMPL(a_rem_bounded, out_valid_o,
                   data[isr_pkg::NumStages].rem <= {1'b0, root_o, 1'b0})
  `ISR_ASSERT_NEXT(a_first_stage_loads, in_valid_i && in_ready_o, vld[1])

endmodule

// ===== sv/isr_stage.sv =====
`timescale 1ns / 1ps

module isr_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  isr_pkg::isr_data_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output isr_pkg::isr_data_t data_o
);

  logic               valid_q;
  isr_pkg::isr_data_t data_q;
  isr_pkg::isr_data_t data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d = data_i;
    for (int unsigned i = 0; i < isr_pkg::ItersPerStage; i++) begin
      data_d = isr_pkg::isr_iter(data_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // advance payload only on an accepted beat
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
